>>> design/isbe_pkg.sv
// ----------------------------------------------------------------------------
// isbe_pkg: shared types and constants for the serial shift engine
// Request and status codes, register layout, state and word formats.
// ----------------------------------------------------------------------------
package isbe_pkg;

  localparam int unsigned MaxBits   = 64;
  localparam int unsigned PortWidth = 8;

  localparam logic [1:0] RisingSlot  = 2'd2;
  localparam logic [1:0] FallingSlot = 2'd3;
  localparam logic [1:0] LastSlot    = 2'd3;

  localparam logic [PortWidth-1:0] DirReset = 8'hBB;

  typedef enum logic [2:0] {
    REQ_PIN_WRITE = 3'd0,
    REQ_PIN_READ  = 3'd1,
    REQ_SHIFT_OUT = 3'd2,
    REQ_SHIFT_IN  = 3'd3,
    REQ_TICK      = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BUSY      = 2'd1,
    STATUS_BAD_COUNT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_CLOCK_PIN         = 3'd0,
    REG_DATA_OUT_PIN      = 3'd1,
    REG_DATA_IN_PIN       = 3'd2,
    REG_LEAD_MSB          = 3'd3,
    REG_SAMPLE_ON_FALLING = 3'd4
  } reg_e;

  typedef struct packed {
    logic [2:0] clock_pin;
    logic [2:0] data_out_pin;
    logic [2:0] data_in_pin;
    logic       lead_msb;
    logic       sample_on_falling;
  } cfg_t;

  typedef struct packed {
    logic [PortWidth-1:0] latch;
    logic [PortWidth-1:0] dir;
    logic                 busy;
    logic                 shifting_in;
    logic [6:0]           bits_left;
    logic [1:0]           slot;
    logic [MaxBits-1:0]   bit_select;
    logic [MaxBits-1:0]   out_value;
    logic [MaxBits-1:0]   capture;
  } state_t;

  typedef struct packed {
    logic [2:0]           req_type;
    logic [2:0]           pin_index;
    logic                 pin_level;
    logic [MaxBits-1:0]   shift_data;
    logic [6:0]           bit_count;
    logic [PortWidth-1:0] port_in;
  } in_word_t;

  typedef struct packed {
    logic [PortWidth-1:0] port_out;
    logic [PortWidth-1:0] port_dir;
    logic                 read_level;
    logic [MaxBits-1:0]   shift_result;
    logic                 done_res;
    logic [1:0]           status;
  } out_word_t;

  localparam cfg_t CfgReset = '{
    clock_pin:         3'd0,
    data_out_pin:      3'd1,
    data_in_pin:       3'd1,
    lead_msb:          1'b0,
    sample_on_falling: 1'b0
  };

  localparam state_t StateReset = '{
    latch:       '0,
    dir:         DirReset,
    busy:        1'b0,
    shifting_in: 1'b0,
    bits_left:   '0,
    slot:        '0,
    bit_select:  '0,
    out_value:   '0,
    capture:     '0
  };

  function automatic logic [PortWidth-1:0] pin_bit(input logic [2:0] pin);
    pin_bit = 8'(1) << pin;
  endfunction

endpackage

>>> design/isbe_in_if.sv
// ----------------------------------------------------------------------------
// isbe_in_if: request channel
// Valid/ready channel that carries one request word.
// ----------------------------------------------------------------------------
interface isbe_in_if;
  import isbe_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

>>> design/isbe_out_if.sv
// ----------------------------------------------------------------------------
// isbe_out_if: result channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface isbe_out_if;
  import isbe_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

>>> design/icsp_bitbang_shift_engine.sv
// ----------------------------------------------------------------------------
// icsp_bitbang_shift_engine: bit-banged serial shift master
// Keeps an 8-bit port latch and direction mask and plays shift waveforms.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on in_i, one word per accepted handshake; every request
// produces exactly one result word on out_o. A request is a pin write, a pin
// read, a shift command (1 to 64 bits) or a tick. After a shift command each
// tick advances the waveform by one slot (data, clock high, clock high, clock
// low per bit); the tick that ends the transfer reports done and, for a shift
// in, the captured value.
// The result word is registered on acceptance. The engine takes one request
// per cycle while out_o takes each result: the whole update is a single
// combinational pass from the state registers into the result register.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes pin
// assignments, bit order and sample edge; write it only while idle.
// Reset puts the latch at 0, the direction mask at 0xBB and the engine idle.
// When out_o stalls, the result register holds its word and in_i drops ready
// until that word is taken.
// ----------------------------------------------------------------------------
module icsp_bitbang_shift_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [2:0] cfg_wdata_i,
  isbe_in_if.sink    in_i,
  isbe_out_if.source out_o
);
  import isbe_pkg::*;

  cfg_t      cfg_q;
  state_t    state_q;
  state_t    state_d;
  out_word_t res_d;
  out_word_t res_q;
  logic      out_valid_q;
  logic      in_fire;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = res_q;

  isbe_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .word_i  (in_i.item),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CLOCK_PIN:         cfg_q.clock_pin         <= cfg_wdata_i;
        REG_DATA_OUT_PIN:      cfg_q.data_out_pin      <= cfg_wdata_i;
        REG_DATA_IN_PIN:       cfg_q.data_in_pin       <= cfg_wdata_i;
        REG_LEAD_MSB:          cfg_q.lead_msb          <= cfg_wdata_i[0];
        REG_SAMPLE_ON_FALLING: cfg_q.sample_on_falling <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  // A running transfer always has bits left to play.
  a_busy_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.busy |-> (state_q.bits_left != 7'd0))
    else $error("busy with no bits left");

  // The bit select never holds more than one bit.
  a_select_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(state_q.bit_select))
    else $error("bit select not one-hot");

  // Every accepted request leaves a result word waiting.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted request produced no result");

  // A finishing tick leaves the engine idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_d.done_res) |=> !state_q.busy)
    else $error("engine still busy after done");

  // Status busy is only reported while a transfer runs.
  a_busy_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (res_d.status == STATUS_BUSY)) |-> state_q.busy)
    else $error("busy status while idle");

endmodule

>>> design/isbe_step.sv
// ----------------------------------------------------------------------------
// isbe_step: next-state and result logic
// Applies one request word to the engine state and forms its result word.
// ----------------------------------------------------------------------------
module isbe_step (
  input  isbe_pkg::cfg_t      cfg_i,
  input  isbe_pkg::state_t    state_i,
  input  isbe_pkg::in_word_t  word_i,
  output isbe_pkg::state_t    state_o,
  output isbe_pkg::out_word_t res_o
);
  import isbe_pkg::*;

  logic [1:0]         sample_slot;
  logic [5:0]         msb_idx;
  logic               bad_count;
  logic [6:0]         bits_next;
  logic [MaxBits-1:0] capture_next;

  assign sample_slot = cfg_i.sample_on_falling ? FallingSlot : RisingSlot;
  assign msb_idx     = 6'(word_i.bit_count - 7'd1);
  assign bad_count   = (word_i.bit_count == 7'd0) || (word_i.bit_count > 7'(MaxBits));
  assign bits_next   = state_i.bits_left - 7'd1;

  always_comb begin
    capture_next = state_i.capture;
    if (state_i.shifting_in && (state_i.slot == sample_slot) &&
        ((word_i.port_in & pin_bit(cfg_i.data_in_pin)) != '0)) begin
      capture_next = state_i.capture | state_i.bit_select;
    end
  end

  always_comb begin
    state_o          = state_i;
    res_o            = '0;
    res_o.status     = STATUS_OK;

    if ((word_i.req_type <= REQ_SHIFT_IN) && state_i.busy) begin
      res_o.status = STATUS_BUSY;
    end else begin
      case (req_e'(word_i.req_type))
        REQ_PIN_WRITE: begin
          state_o.dir = state_i.dir | pin_bit(word_i.pin_index);
          if (word_i.pin_level) begin
            state_o.latch = state_i.latch | pin_bit(word_i.pin_index);
          end else begin
            state_o.latch = state_i.latch & ~pin_bit(word_i.pin_index);
          end
        end
        REQ_PIN_READ: begin
          state_o.dir      = state_i.dir & ~pin_bit(word_i.pin_index);
          res_o.read_level = (word_i.port_in & pin_bit(word_i.pin_index)) != '0;
        end
        REQ_SHIFT_OUT, REQ_SHIFT_IN: begin
          if (bad_count) begin
            res_o.status = STATUS_BAD_COUNT;
          end else begin
            state_o.shifting_in = (word_i.req_type == REQ_SHIFT_IN);
            // A shared data pin turns around with the transfer direction.
            if (cfg_i.data_in_pin == cfg_i.data_out_pin) begin
              if (word_i.req_type == REQ_SHIFT_IN) begin
                state_o.dir = state_i.dir & ~pin_bit(cfg_i.data_in_pin);
              end else begin
                state_o.dir = state_i.dir | pin_bit(cfg_i.data_in_pin);
              end
            end
            state_o.busy       = 1'b1;
            state_o.bits_left  = word_i.bit_count;
            state_o.slot       = 2'd0;
            state_o.bit_select = cfg_i.lead_msb ? (64'(1) << msb_idx) : 64'(1);
            state_o.out_value  = (word_i.req_type == REQ_SHIFT_IN) ? '0 : word_i.shift_data;
            state_o.capture    = '0;
          end
        end
        REQ_TICK: begin
          if (state_i.busy) begin
            case (state_i.slot)
              2'd0: begin
                if (!state_i.shifting_in) begin
                  if ((state_i.out_value & state_i.bit_select) != '0) begin
                    state_o.latch = state_i.latch | pin_bit(cfg_i.data_out_pin);
                  end else begin
                    state_o.latch = state_i.latch & ~pin_bit(cfg_i.data_out_pin);
                  end
                end
              end
              2'd1: state_o.latch = state_i.latch | pin_bit(cfg_i.clock_pin);
              2'd2: state_o.latch = state_i.latch;
              default: state_o.latch = state_i.latch & ~pin_bit(cfg_i.clock_pin);
            endcase

            state_o.capture = capture_next;

            if (state_i.slot == LastSlot) begin
              state_o.bit_select = cfg_i.lead_msb ? (state_i.bit_select >> 1)
                                                  : (state_i.bit_select << 1);
              state_o.bits_left  = bits_next;
              state_o.slot       = 2'd0;
              if (bits_next == 7'd0) begin
                state_o.busy       = 1'b0;
                res_o.done_res     = 1'b1;
                res_o.shift_result = state_i.shifting_in ? capture_next : '0;
              end
            end else begin
              state_o.slot = state_i.slot + 2'd1;
            end
          end
        end
        default: begin
          // Unknown request codes leave everything untouched.
          state_o = state_i;
        end
      endcase
    end

    res_o.port_out = state_o.latch;
    res_o.port_dir = state_o.dir;
  end

endmodule
